[rtl/rcpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rcpd_pkg;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Packet framing and button bits of the buttons byte.
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam int         BTN_SIREN    = 0;
    localparam int         BTN_CLAW_R   = 1;
    localparam int         BTN_ARM_UP   = 2;
    localparam int         BTN_ARM_DOWN = 3;
    localparam int         BTN_CLAW_L   = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SIREN_HALF  = 3'd0;
    localparam logic [2:0] CFG_MS_PER_STEP = 3'd1;
    localparam logic [2:0] CFG_ROTATE_MIN  = 3'd2;
    localparam logic [2:0] CFG_ROTATE_MAX  = 3'd3;
    localparam logic [2:0] CFG_ARM_MIN     = 3'd4;
    localparam logic [2:0] CFG_ARM_MAX     = 3'd5;
    localparam logic [2:0] CFG_GRIP_OPEN   = 3'd6;
    localparam logic [2:0] CFG_GRIP_CLOSED = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_SIREN_HALF  = 16'd500;
    localparam logic [7:0]  RST_MS_PER_STEP = 8'd18;
    localparam logic [7:0]  RST_ROTATE_MIN  = 8'd0;
    localparam logic [7:0]  RST_ROTATE_MAX  = 8'd250;
    localparam logic [7:0]  RST_ARM_MIN     = 8'd10;
    localparam logic [7:0]  RST_ARM_MAX     = 8'd164;
    localparam logic [7:0]  RST_GRIP_OPEN   = 8'd55;
    localparam logic [7:0]  RST_GRIP_CLOSED = 8'd140;

    // Power-up positions of the servos.
    localparam logic [7:0] ROTATE_HOME = 8'd108;
    localparam logic [7:0] ARM_HOME    = 8'd114;
    localparam logic [7:0] GRIP_HOME   = 8'd55;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_MAX  = 2'd1,
        DIR_MIN  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_X    = 3'd1,
        PH_Y    = 3'd2,
        PH_DIAL = 3'd3,
        PH_BTN  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        TONE_SILENT = 2'd0,
        TONE_HI     = 2'd1,
        TONE_LO     = 2'd2
    } t_siren;

    // Per-word control of one servo channel.
    typedef struct packed {
        logic tick;
        logic pkt;
        t_dir want;
    } t_servo_ctl;

    // Command issued by one servo channel.
    typedef struct packed {
        logic       update;
        logic [7:0] target;
    } t_servo_cmd;

    // Wheel drive, packed like the result word.
    typedef struct packed {
        logic [7:0] right_duty;
        logic       right_reverse;
        logic [7:0] left_duty;
        logic       left_reverse;
    } t_drive;

    // Result word; the last member sits in the lowest bits.
    typedef struct packed {
        logic [1:0] siren_tone;
        logic       headlight_on;
        logic [7:0] grip_target;
        logic       grip_update;
        logic [7:0] arm_target;
        logic       arm_update;
        logic [7:0] rotate_target;
        logic       rotate_update;
        t_drive     drive;
    } t_result;

endpackage

`default_nettype wire

[rtl/rcpd_drive_mix.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcpd_drive_mix (
    input  wire logic [7:0]      i_x,
    input  wire logic [7:0]      i_y,
    output rcpd_pkg::t_drive     o_drive
);

    logic        [1:0]  qy;
    logic signed [11:0] base;
    logic        [6:0]  nl;
    logic        [7:0]  mr;
    logic        [1:0]  qn;
    logic signed [11:0] turn;
    logic signed [11:0] l_mix;
    logic signed [11:0] r_mix;

    // Clamp to +-255 and split into direction and magnitude.
    function automatic logic [8:0] split_side(input logic signed [11:0] v);
        logic signed [11:0] c;
        logic        [11:0] mag;
        begin
            if (v < -12'sd255) begin
                c = -12'sd255;
            end else if (v > 12'sd255) begin
                c = 12'sd255;
            end else begin
                c = v;
            end
            mag = c[11] ? 12'(-c) : 12'(c);
            split_side = {mag[7:0], c[11]};
        end
    endfunction

    // Throttle: y*510/254 - 255, where y*255/127 = 2y + y/127.
    always_comb begin
        if (i_y >= 8'd254) begin
            qy = 2'd2;
        end else if (i_y >= 8'd127) begin
            qy = 2'd1;
        end else begin
            qy = 2'd0;
        end
        base = signed'({3'b000, i_y, 1'b0}) + signed'({10'b0, qy}) - 12'sd255;
    end

    // Steering: n*255/126 = 2n + n/42 on the left, m*255/127 = 2m + m/127 on the right.
    always_comb begin
        nl = 7'd126 - i_x[6:0];
        mr = i_x - 8'd127;
        if (nl >= 7'd126) begin
            qn = 2'd3;
        end else if (nl >= 7'd84) begin
            qn = 2'd2;
        end else if (nl >= 7'd42) begin
            qn = 2'd1;
        end else begin
            qn = 2'd0;
        end
        if (i_x < 8'd127) begin
            turn  = signed'({4'b0, nl, 1'b0}) + signed'({10'b0, qn});
            l_mix = base - turn;
            r_mix = base + turn;
        end else begin
            turn  = signed'({3'b0, mr, 1'b0}) + signed'({11'b0, (mr >= 8'd127)});
            l_mix = base + turn;
            r_mix = base - turn;
        end
    end

    assign {o_drive.left_duty, o_drive.left_reverse}   = split_side(l_mix);
    assign {o_drive.right_duty, o_drive.right_reverse} = split_side(r_mix);

endmodule

`default_nettype wire

[rtl/rcpd_grip_map.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcpd_grip_map (
    input  wire logic [7:0] i_dial,
    input  wire logic [7:0] i_open,
    input  wire logic [7:0] i_closed,
    output logic      [7:0] o_grip
);

    logic signed [8:0]  diff;
    logic        [7:0]  span;
    logic        [15:0] prod;
    logic        [7:0]  q0;
    logic        [9:0]  rem;
    logic        [8:0]  quot;
    logic signed [10:0] sq;
    logic signed [10:0] g;

    // dial * (closed - open) / 254, truncated toward zero, plus open.
    always_comb begin
        diff = signed'({1'b0, i_closed}) - signed'({1'b0, i_open});
        span = diff[8] ? 8'(-diff) : diff[7:0];
        prod = i_dial * span;
        // prod = 254*q0 + rem with rem below four times 254.
        q0   = prod[15:8];
        rem  = {2'b00, prod[7:0]} + {1'b0, q0, 1'b0};
        if (rem >= 10'd762) begin
            quot = {1'b0, q0} + 9'd3;
        end else if (rem >= 10'd508) begin
            quot = {1'b0, q0} + 9'd2;
        end else if (rem >= 10'd254) begin
            quot = {1'b0, q0} + 9'd1;
        end else begin
            quot = {1'b0, q0};
        end
        sq = diff[8] ? -signed'({2'b00, quot}) : signed'({2'b00, quot});
        g  = sq + signed'({3'b000, i_open});
        if (g < 11'sd0) begin
            o_grip = 8'd0;
        end else if (g > 11'sd255) begin
            o_grip = 8'd255;
        end else begin
            o_grip = g[7:0];
        end
    end

endmodule

`default_nettype wire

[rtl/rcpd_servo.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcpd_servo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rcpd_pkg::t_servo_ctl i_ctl,
    input  wire logic [7:0]           i_home,
    input  wire logic [7:0]           i_lo,
    input  wire logic [7:0]           i_hi,
    input  wire logic [7:0]           i_ms_per_step,
    output rcpd_pkg::t_servo_cmd      o_cmd
);

    rcpd_pkg::t_dir     r_dir, n_dir, dir_cur;
    logic [7:0]         r_pos, n_pos;
    logic [7:0]         r_ms, n_ms;
    logic [7:0]         r_steps, n_steps;
    logic [7:0]         ms_inc;
    logic               moving;
    logic signed [9:0]  pos_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= rcpd_pkg::DIR_STOP;
            r_pos   <= i_home;
            r_ms    <= '0;
            r_steps <= '0;
        end else begin
            r_dir   <= n_dir;
            r_pos   <= n_pos;
            r_ms    <= n_ms;
            r_steps <= n_steps;
        end
    end

    // Dead reckoning: count ticks into steps while moving, settle on stop.
    always_comb begin
        n_dir   = r_dir;
        n_pos   = r_pos;
        n_ms    = r_ms;
        n_steps = r_steps;
        o_cmd   = '0;
        moving  = (r_dir == rcpd_pkg::DIR_MAX) || (r_dir == rcpd_pkg::DIR_MIN);
        dir_cur = moving ? r_dir : rcpd_pkg::DIR_STOP;
        ms_inc  = r_ms + 8'd1;
        pos_est = (r_dir == rcpd_pkg::DIR_MAX) ?
                  signed'({2'b00, r_pos}) + signed'({2'b00, r_steps}) :
                  signed'({2'b00, r_pos}) - signed'({2'b00, r_steps});

        if (i_ctl.tick && moving) begin
            if (ms_inc >= i_ms_per_step) begin
                n_ms = '0;
                if (r_steps != 8'hFF) begin
                    n_steps = r_steps + 8'd1;
                end
            end else begin
                n_ms = ms_inc;
            end
        end

        if (i_ctl.pkt) begin
            // Stop: the lower limit is tested first.
            if (moving && (i_ctl.want != r_dir)) begin
                if (pos_est < signed'({2'b00, i_lo})) begin
                    n_pos = i_lo;
                end else if (pos_est > signed'({2'b00, i_hi})) begin
                    n_pos = i_hi;
                end else begin
                    n_pos = pos_est[7:0];
                end
                dir_cur      = rcpd_pkg::DIR_STOP;
                n_dir        = rcpd_pkg::DIR_STOP;
                o_cmd.update = 1'b1;
                o_cmd.target = n_pos;
            end
            // Start a move toward a limit; this command replaces a stop.
            if ((i_ctl.want != rcpd_pkg::DIR_STOP) && (i_ctl.want != dir_cur)) begin
                n_dir        = i_ctl.want;
                o_cmd.update = 1'b1;
                o_cmd.target = (i_ctl.want == rcpd_pkg::DIR_MIN) ? i_lo : i_hi;
                n_ms         = '0;
                n_steps      = '0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/rc_packet_drive_servo_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                                     Word
// s_axis    in         s_axis_tvalid/tready, tdata[7:0], tuser     radio byte or ms tick
// m_axis    out        m_axis_tvalid/tready, tdata[47:0]           drive, servo, light, siren
// cfg       in         i_cfg_valid, o_cfg_ready, index[2:0], data  register write
//
// One word in gives one word out; the block takes a word every cycle unless m_axis stalls.
// An accepted word goes to the input register, then to the result register on m_axis.
// All packet and tick work is done by the logic between those two registers.
// Reset is synchronous and restores registers and servo positions at once.
// A stalled output holds the result register; the input register fills, then
// s_axis_tready drops.

module rc_packet_drive_servo_controller_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] left_reverse, [8:1] left_duty, [9] right_reverse, [17:10] right_duty,
    // [18] rotate_update, [26:19] rotate_target, [27] arm_update, [35:28] arm_target,
    // [36] grip_update, [44:37] grip_target, [45] headlight_on, [47:46] siren_tone
    output logic [47:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_siren_half;
    logic [7:0]  r_ms_per_step, r_rotate_min, r_rotate_max;
    logic [7:0]  r_arm_min, r_arm_max, r_grip_open, r_grip_closed;

    // Input and result stages.
    logic                r_in_valid;
    logic                r_in_op;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    rcpd_pkg::t_result   r_out, n_out;
    logic                advance;

    // Packet and controller state.
    rcpd_pkg::t_phase    r_phase, n_phase;
    logic [7:0]          r_x, n_x, r_y, n_y, r_dial, n_dial;
    logic                r_chord, n_chord, r_light, n_light;
    logic [7:0]          r_last_grip, n_last_grip;
    rcpd_pkg::t_siren    r_siren, n_siren;
    logic [15:0]         r_elapsed, n_elapsed;
    logic [15:0]         elapsed_inc;
    rcpd_pkg::t_drive    r_drive, n_drive;

    logic                pkt_done;
    logic [7:0]          btn;
    rcpd_pkg::t_servo_ctl rot_ctl, arm_ctl;
    rcpd_pkg::t_servo_cmd rot_cmd, arm_cmd;
    rcpd_pkg::t_drive    mix_drive;
    logic [7:0]          grip_map;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siren_half  <= rcpd_pkg::RST_SIREN_HALF;
            r_ms_per_step <= rcpd_pkg::RST_MS_PER_STEP;
            r_rotate_min  <= rcpd_pkg::RST_ROTATE_MIN;
            r_rotate_max  <= rcpd_pkg::RST_ROTATE_MAX;
            r_arm_min     <= rcpd_pkg::RST_ARM_MIN;
            r_arm_max     <= rcpd_pkg::RST_ARM_MAX;
            r_grip_open   <= rcpd_pkg::RST_GRIP_OPEN;
            r_grip_closed <= rcpd_pkg::RST_GRIP_CLOSED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rcpd_pkg::CFG_SIREN_HALF:  r_siren_half  <= i_cfg_data;
                rcpd_pkg::CFG_MS_PER_STEP: r_ms_per_step <= i_cfg_data[7:0];
                rcpd_pkg::CFG_ROTATE_MIN:  r_rotate_min  <= i_cfg_data[7:0];
                rcpd_pkg::CFG_ROTATE_MAX:  r_rotate_max  <= i_cfg_data[7:0];
                rcpd_pkg::CFG_ARM_MIN:     r_arm_min     <= i_cfg_data[7:0];
                rcpd_pkg::CFG_ARM_MAX:     r_arm_max     <= i_cfg_data[7:0];
                rcpd_pkg::CFG_GRIP_OPEN:   r_grip_open   <= i_cfg_data[7:0];
                rcpd_pkg::CFG_GRIP_CLOSED: r_grip_closed <= i_cfg_data[7:0];
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Controller state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rcpd_pkg::PH_HUNT;
            r_x         <= '0;
            r_y         <= '0;
            r_dial      <= '0;
            r_chord     <= 1'b0;
            r_light     <= 1'b0;
            r_last_grip <= rcpd_pkg::GRIP_HOME;
            r_siren     <= rcpd_pkg::TONE_SILENT;
            r_elapsed   <= '0;
            r_drive     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_x         <= n_x;
            r_y         <= n_y;
            r_dial      <= n_dial;
            r_chord     <= n_chord;
            r_light     <= n_light;
            r_last_grip <= n_last_grip;
            r_siren     <= n_siren;
            r_elapsed   <= n_elapsed;
            r_drive     <= n_drive;
        end
    end

    assign btn      = r_in_byte;
    assign pkt_done = advance && (r_in_op == rcpd_pkg::OP_BYTE) && (r_phase == rcpd_pkg::PH_BTN);

    // Servo requests from the buttons byte; a held claw chord freezes rotate.
    always_comb begin
        rot_ctl.tick = advance && (r_in_op == rcpd_pkg::OP_TICK);
        rot_ctl.pkt  = pkt_done && !(btn[rcpd_pkg::BTN_CLAW_L] && btn[rcpd_pkg::BTN_CLAW_R]);
        rot_ctl.want = btn[rcpd_pkg::BTN_CLAW_R] ? rcpd_pkg::DIR_MAX :
                       (btn[rcpd_pkg::BTN_CLAW_L] ? rcpd_pkg::DIR_MIN : rcpd_pkg::DIR_STOP);
        arm_ctl.tick = rot_ctl.tick;
        arm_ctl.pkt  = pkt_done;
        arm_ctl.want = btn[rcpd_pkg::BTN_ARM_UP] ? rcpd_pkg::DIR_MIN :
                       (btn[rcpd_pkg::BTN_ARM_DOWN] ? rcpd_pkg::DIR_MAX : rcpd_pkg::DIR_STOP);
    end

    rcpd_servo u_rotate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (rot_ctl),
        .i_home        (rcpd_pkg::ROTATE_HOME),
        .i_lo          (r_rotate_min),
        .i_hi          (r_rotate_max),
        .i_ms_per_step (r_ms_per_step),
        .o_cmd         (rot_cmd)
    );

    rcpd_servo u_arm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (arm_ctl),
        .i_home        (rcpd_pkg::ARM_HOME),
        .i_lo          (r_arm_min),
        .i_hi          (r_arm_max),
        .i_ms_per_step (r_ms_per_step),
        .o_cmd         (arm_cmd)
    );

    rcpd_drive_mix u_mix (
        .i_x     (r_x),
        .i_y     (r_y),
        .o_drive (mix_drive)
    );

    rcpd_grip_map u_grip (
        .i_dial   (r_dial),
        .i_open   (r_grip_open),
        .i_closed (r_grip_closed),
        .o_grip   (grip_map)
    );

    // Packet parser, headlight chord, siren and result assembly.
    always_comb begin
        n_phase     = r_phase;
        n_x         = r_x;
        n_y         = r_y;
        n_dial      = r_dial;
        n_chord     = r_chord;
        n_light     = r_light;
        n_last_grip = r_last_grip;
        n_siren     = r_siren;
        n_elapsed   = r_elapsed;
        n_drive     = r_drive;
        elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
        n_out       = '0;

        if (advance) begin
            if (r_in_op == rcpd_pkg::OP_TICK) begin
                // Siren tone flips once the count passes the half period.
                if ((r_siren == rcpd_pkg::TONE_HI) || (r_siren == rcpd_pkg::TONE_LO)) begin
                    if (elapsed_inc > r_siren_half) begin
                        n_siren   = (r_siren == rcpd_pkg::TONE_HI) ?
                                    rcpd_pkg::TONE_LO : rcpd_pkg::TONE_HI;
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
            end else begin
                unique case (r_phase)
                    rcpd_pkg::PH_X: begin
                        n_x     = r_in_byte;
                        n_phase = rcpd_pkg::PH_Y;
                    end
                    rcpd_pkg::PH_Y: begin
                        n_y     = r_in_byte;
                        n_phase = rcpd_pkg::PH_DIAL;
                    end
                    rcpd_pkg::PH_DIAL: begin
                        n_dial  = r_in_byte;
                        n_phase = rcpd_pkg::PH_BTN;
                    end
                    rcpd_pkg::PH_BTN: begin
                        n_phase = rcpd_pkg::PH_HUNT;
                        n_drive = mix_drive;
                        if (btn[rcpd_pkg::BTN_CLAW_L] && btn[rcpd_pkg::BTN_CLAW_R]) begin
                            n_chord = 1'b1;
                        end else if (r_chord) begin
                            n_light = !r_light;
                            n_chord = 1'b0;
                        end
                        if (grip_map != r_last_grip) begin
                            n_last_grip       = grip_map;
                            n_out.grip_update = 1'b1;
                        end
                        if (!btn[rcpd_pkg::BTN_SIREN]) begin
                            n_siren = rcpd_pkg::TONE_SILENT;
                        end else if ((r_siren != rcpd_pkg::TONE_HI) &&
                                     (r_siren != rcpd_pkg::TONE_LO)) begin
                            n_siren   = rcpd_pkg::TONE_HI;
                            n_elapsed = '0;
                        end
                    end
                    default: begin
                        n_phase = (r_in_byte == rcpd_pkg::SYNC_BYTE) ?
                                  rcpd_pkg::PH_X : rcpd_pkg::PH_HUNT;
                    end
                endcase
            end
        end

        n_out.drive         = n_drive;
        n_out.rotate_update = rot_cmd.update;
        n_out.rotate_target = rot_cmd.update ? rot_cmd.target : 8'd0;
        n_out.arm_update    = arm_cmd.update;
        n_out.arm_target    = arm_cmd.update ? arm_cmd.target : 8'd0;
        n_out.grip_target   = n_last_grip;
        n_out.headlight_on  = n_light;
        n_out.siren_tone    = n_siren;
    end

`ifndef SYNTHESIS
    // A word in the input register is never dropped while the output stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input word lost during stall");

    // Ticks never issue servo or grip commands.
    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_op == rcpd_pkg::OP_TICK) |=>
        !r_out.rotate_update && !r_out.arm_update && !r_out.grip_update)
        else $error("tick produced a command");

    // Ticks do not move the packet parser.
    a_tick_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_op == rcpd_pkg::OP_TICK) |=> $stable(r_phase))
        else $error("tick changed parser phase");

    // A held claw chord suppresses rotate commands.
    a_chord_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pkt_done && btn[rcpd_pkg::BTN_CLAW_L] && btn[rcpd_pkg::BTN_CLAW_R] |=>
        !r_out.rotate_update && r_chord)
        else $error("rotate command during claw chord");
`endif

endmodule

`default_nettype wire

[sim/rc_packet_drive_servo_controller_top_tb.sv]
`timescale 1ns / 1ps

module rc_packet_drive_servo_controller_top_tb;
    import rcpd_pkg::*;

    // One input word: item kind and the radio byte.
    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } t_radio_word;

    // Dead-reckoning state of one servo channel.
    typedef struct packed {
        logic [7:0] pos;
        t_dir       dir;
        logic [7:0] ms;
        logic [7:0] steps;
    } t_servo_st;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [15:0] i_cfg_data = 16'h0000;

    rc_packet_drive_servo_controller_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and scoreboard storage.
    t_radio_word pending_words[$];
    t_result     expected_responses[$];
    int          queued_words = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    bit          quiet_tail = 1'b0;

    // Predictor copy of the configuration.
    logic [15:0] cfg_siren_half;
    logic [7:0]  cfg_ms_step;
    logic [7:0]  cfg_rot_min;
    logic [7:0]  cfg_rot_max;
    logic [7:0]  cfg_arm_min;
    logic [7:0]  cfg_arm_max;
    logic [7:0]  cfg_grip_open;
    logic [7:0]  cfg_grip_closed;

    // Predictor copy of the controller state.
    t_phase      rx_ph;
    logic [7:0]  x_b;
    logic [7:0]  y_b;
    logic [7:0]  dial_b;
    logic        chord;
    logic        light;
    t_servo_st   rot_sv;
    t_servo_st   arm_sv;
    logic [7:0]  grip_pos;
    t_siren      siren_md;
    int          siren_ms;
    t_drive      drive_st;

    task automatic reset_model();
        cfg_siren_half  = RST_SIREN_HALF;
        cfg_ms_step     = RST_MS_PER_STEP;
        cfg_rot_min     = RST_ROTATE_MIN;
        cfg_rot_max     = RST_ROTATE_MAX;
        cfg_arm_min     = RST_ARM_MIN;
        cfg_arm_max     = RST_ARM_MAX;
        cfg_grip_open   = RST_GRIP_OPEN;
        cfg_grip_closed = RST_GRIP_CLOSED;
        rx_ph    = PH_HUNT;
        x_b      = '0;
        y_b      = '0;
        dial_b   = '0;
        chord    = 1'b0;
        light    = 1'b0;
        rot_sv.pos = ROTATE_HOME;
        rot_sv.dir = DIR_STOP;
        rot_sv.ms = '0;
        rot_sv.steps = '0;
        arm_sv.pos = ARM_HOME;
        arm_sv.dir = DIR_STOP;
        arm_sv.ms = '0;
        arm_sv.steps = '0;
        grip_pos = GRIP_HOME;
        siren_md = TONE_SILENT;
        siren_ms = 0;
        drive_st = '0;
    endtask

    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // A moving servo counts one step every ms_per_step ticks, saturating at 255.
    function automatic void count_tick(inout t_servo_st s);
        if (s.dir == DIR_MAX || s.dir == DIR_MIN) begin
            s.ms = s.ms + 8'd1;
            if (s.ms >= cfg_ms_step) begin
                s.ms = '0;
                if (s.steps != 8'hFF) s.steps = s.steps + 8'd1;
            end
        end
    endfunction

    // A change of direction first stops the servo at its reckoned position, then
    // starts the new move; the later command is the one that is reported.
    function automatic logic aim_servo(inout t_servo_st s, input t_dir want,
                                       input logic [7:0] lo, input logic [7:0] hi,
                                       output logic [7:0] tgt);
        int   p;
        logic hit;
        hit = 1'b0;
        tgt = '0;
        if (s.dir != DIR_STOP && want != s.dir) begin
            if (s.dir == DIR_MAX) p = int'(s.pos) + int'(s.steps);
            else p = int'(s.pos) - int'(s.steps);
            p = clamp_to(p, int'(lo), int'(hi));
            s.pos = p[7:0];
            s.dir = DIR_STOP;
            tgt = s.pos;
            hit = 1'b1;
        end
        if (want != DIR_STOP && want != s.dir) begin
            s.dir = want;
            tgt = (want == DIR_MIN) ? lo : hi;
            s.ms = '0;
            s.steps = '0;
            hit = 1'b1;
        end
        return hit;
    endfunction

    // Works out the result word for one accepted input word.
    function automatic t_result compute_response(input logic op, input logic [7:0] b);
        t_result    res;
        int         base;
        int         turn;
        int         lt;
        int         rt;
        int         g;
        t_dir       want;
        logic [7:0] tgt;
        res = '0;
        if (op == OP_TICK) begin
            count_tick(rot_sv);
            count_tick(arm_sv);
            if (siren_md != TONE_SILENT) begin
                if (siren_ms < 65535) siren_ms++;
                if (siren_ms > int'(cfg_siren_half)) begin
                    siren_md = (siren_md == TONE_HI) ? TONE_LO : TONE_HI;
                    siren_ms = 0;
                end
            end
        end else begin
            case (rx_ph)
                PH_HUNT: if (b == SYNC_BYTE) rx_ph = PH_X;
                PH_X: begin
                    x_b = b;
                    rx_ph = PH_Y;
                end
                PH_Y: begin
                    y_b = b;
                    rx_ph = PH_DIAL;
                end
                PH_DIAL: begin
                    dial_b = b;
                    rx_ph = PH_BTN;
                end
                default: begin
                    rx_ph = PH_HUNT;

                    // Arcade mix of stick position into wheel speeds.
                    base = int'(y_b) * 510 / 254 - 255;
                    if (x_b < 8'd127) begin
                        turn = (126 - int'(x_b)) * 255 / 126;
                        lt = base - turn;
                        rt = base + turn;
                    end else begin
                        turn = (int'(x_b) - 127) * 255 / 127;
                        lt = base + turn;
                        rt = base - turn;
                    end
                    lt = clamp_to(lt, -255, 255);
                    rt = clamp_to(rt, -255, 255);
                    drive_st.left_reverse  = (lt < 0);
                    drive_st.left_duty     = (lt < 0) ? 8'(-lt) : 8'(lt);
                    drive_st.right_reverse = (rt < 0);
                    drive_st.right_duty    = (rt < 0) ? 8'(-rt) : 8'(rt);

                    // Both claw buttons form the headlight chord; rotate is frozen then.
                    if (b[BTN_CLAW_L] && b[BTN_CLAW_R]) begin
                        chord = 1'b1;
                    end else begin
                        if (chord) begin
                            light = ~light;
                            chord = 1'b0;
                        end
                        if (b[BTN_CLAW_R]) want = DIR_MAX;
                        else if (b[BTN_CLAW_L]) want = DIR_MIN;
                        else want = DIR_STOP;
                        if (aim_servo(rot_sv, want, cfg_rot_min, cfg_rot_max, tgt)) begin
                            res.rotate_update = 1'b1;
                            res.rotate_target = tgt;
                        end
                    end

                    if (b[BTN_ARM_UP]) want = DIR_MIN;
                    else if (b[BTN_ARM_DOWN]) want = DIR_MAX;
                    else want = DIR_STOP;
                    if (aim_servo(arm_sv, want, cfg_arm_min, cfg_arm_max, tgt)) begin
                        res.arm_update = 1'b1;
                        res.arm_target = tgt;
                    end

                    // Grip follows the dial linearly between the open and closed settings.
                    g = int'(dial_b) * (int'(cfg_grip_closed) - int'(cfg_grip_open)) / 254
                        + int'(cfg_grip_open);
                    g = clamp_to(g, 0, 255);
                    if (g[7:0] != grip_pos) begin
                        grip_pos = g[7:0];
                        res.grip_update = 1'b1;
                    end

                    if (!b[BTN_SIREN]) begin
                        siren_md = TONE_SILENT;
                    end else if (siren_md == TONE_SILENT) begin
                        siren_md = TONE_HI;
                        siren_ms = 0;
                    end
                end
            endcase
        end
        res.drive        = drive_st;
        res.grip_target  = grip_pos;
        res.headlight_on = light;
        res.siren_tone   = siren_md;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("mismatch: %s", what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s got %0d expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Stimulus builders.
    task automatic add_word(input logic op, input logic [7:0] b);
        t_radio_word w;
        w.op = op;
        w.b = b;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_word(OP_TICK, 8'($urandom));
    endtask

    task automatic add_packet(input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] dial, input logic [7:0] btn);
        add_word(OP_BYTE, SYNC_BYTE);
        add_word(OP_BYTE, x);
        add_word(OP_BYTE, y);
        add_word(OP_BYTE, dial);
        add_word(OP_BYTE, btn);
    endtask

    // Half edge values of the stick and dial, the rest anything.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd126;
            3: return 8'd127;
            4: return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    // Well-formed packets with random content, tick runs, stray bytes and
    // packets cut short.
    task automatic add_traffic(input int n_words, input int long_run);
        int goal;
        int pick;
        goal = queued_words + n_words;
        while (queued_words < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                add_packet(pick_byte(), pick_byte(), pick_byte(), 8'($urandom));
            end else if (pick < 85) begin
                add_ticks($urandom_range(1, 40));
            end else if (pick < 88 && long_run > 0) begin
                add_ticks($urandom_range(long_run / 2, long_run));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 3))
                    add_word(OP_BYTE, ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
            end else begin
                add_word(OP_BYTE, SYNC_BYTE);
                repeat ($urandom_range(1, 3)) add_word(OP_BYTE, pick_byte());
            end
        end
    endtask

    // Register write over the configuration channel; the predictor follows it.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SIREN_HALF:  cfg_siren_half  = val;
            CFG_MS_PER_STEP: cfg_ms_step     = val[7:0];
            CFG_ROTATE_MIN:  cfg_rot_min     = val[7:0];
            CFG_ROTATE_MAX:  cfg_rot_max     = val[7:0];
            CFG_ARM_MIN:     cfg_arm_min     = val[7:0];
            CFG_ARM_MAX:     cfg_arm_max     = val[7:0];
            CFG_GRIP_OPEN:   cfg_grip_open   = val[7:0];
            CFG_GRIP_CLOSED: cfg_grip_closed = val[7:0];
            default: ;
        endcase
    endtask

    // Byte registers get random upper data bits, which the block must drop.
    task automatic write_all(input logic [15:0] half, input logic [7:0] ms,
                             input logic [7:0] rmin, input logic [7:0] rmax,
                             input logic [7:0] amin, input logic [7:0] amax,
                             input logic [7:0] gopen, input logic [7:0] gclosed);
        write_reg(CFG_SIREN_HALF, half);
        write_reg(CFG_MS_PER_STEP, {8'($urandom), ms});
        write_reg(CFG_ROTATE_MIN, {8'($urandom), rmin});
        write_reg(CFG_ROTATE_MAX, {8'($urandom), rmax});
        write_reg(CFG_ARM_MIN, {8'($urandom), amin});
        write_reg(CFG_ARM_MAX, {8'($urandom), amax});
        write_reg(CFG_GRIP_OPEN, {8'($urandom), gopen});
        write_reg(CFG_GRIP_CLOSED, {8'($urandom), gclosed});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_responses.size() != 0)
            @(negedge i_clk);
    endtask

    // Source side: predict on each accepted word, then offer the next one.
    int src_gap = 0;
    bit src_lively = 1'b1;

    always @(posedge i_clk) begin
        t_radio_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_responses.push_back(compute_response(s_axis_tuser, s_axis_tdata));
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= w.op;
                    s_axis_tdata  <= w.b;
                    if (!quiet_tail && src_lively && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 14);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if ($urandom_range(0, 63) == 0) src_lively = !src_lively;
        end
    end

    // Sink side ready: random stall bursts, plus one long hold-off once the
    // source has a backlog, so the block fills and stalls its input.
    int  sink_stall = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    bit  sink_lively = 1'b1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held_once && words_sent >= 100 && pending_words.size() > 20) begin
                held_once = 1'b1;
                hold_left = 79;
                m_axis_tready <= 1'b0;
            end else if (sink_stall != 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && sink_lively && $urandom_range(0, 7) == 0) begin
                sink_stall = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0) sink_lively = !sink_lively;
        end
    end

    // Result checker: every accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (expected_responses.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing outstanding",
                                          results_seen));
            end else begin
                want = expected_responses.pop_front();
                check_field("left_reverse", got.drive.left_reverse, want.drive.left_reverse);
                check_field("left_duty", got.drive.left_duty, want.drive.left_duty);
                check_field("right_reverse", got.drive.right_reverse,
                            want.drive.right_reverse);
                check_field("right_duty", got.drive.right_duty, want.drive.right_duty);
                check_field("rotate_update", got.rotate_update, want.rotate_update);
                check_field("rotate_target", got.rotate_target, want.rotate_target);
                check_field("arm_update", got.arm_update, want.arm_update);
                check_field("arm_target", got.arm_target, want.arm_target);
                check_field("grip_update", got.grip_update, want.grip_update);
                check_field("grip_target", got.grip_target, want.grip_target);
                check_field("headlight_on", got.headlight_on, want.headlight_on);
                check_field("siren_tone", got.siren_tone, want.siren_tone);
            end
            results_seen++;
        end
    end

    // Test sequence: directed packets at reset settings, then random phases
    // under extreme and random settings, the last one without idling.
    initial begin
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stray byte while hunting, then neutral stick with siren on.
        add_word(OP_BYTE, 8'h00);
        add_packet(8'd127, 8'd127, 8'd0, 8'h01);
        // Full reverse spin, rotate toward max, arm down, dial beyond 254.
        add_packet(8'd0, 8'd0, 8'd255, 8'h0A);
        add_ticks(1);
        // Overflowing forward mix; both servos reverse inside one packet.
        add_packet(8'd255, 8'd255, 8'd254, 8'h14);
        // Claw chord held, then released: headlight toggles, servos stop.
        add_packet(8'd126, 8'd255, 8'd127, 8'h12);
        add_packet(8'd127, 8'd0, 8'd0, 8'hE0);
        add_traffic(160, 0);
        wait_idle();

        // Zero step time and zero half period, widest limits and grip span.
        write_all(16'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        add_traffic(350, 300);
        wait_idle();

        // Slowest settings, crossed limits and an inverted grip.
        write_all(16'hFFFF, 8'd255, 8'd200, 8'd50, 8'd255, 8'd0, 8'd255, 8'd0);
        add_traffic(200, 0);
        wait_idle();

        write_all(16'd1, 8'd1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
        add_traffic(200, 60);
        wait_idle();

        write_all(16'($urandom_range(0, 30)), 8'($urandom_range(1, 6)), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        add_traffic(200, 40);
        wait_idle();

        quiet_tail = 1'b1;
        write_all(16'($urandom_range(0, 20)), 8'($urandom_range(1, 4)), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        add_traffic(200, 30);
        wait_idle();

        repeat (10) @(negedge i_clk);
        if (expected_responses.size() != 0)
            report_mismatch($sformatf("%0d predicted words never arrived",
                                      expected_responses.size()));
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/rcpd_pkg.sv
rtl/rcpd_drive_mix.sv
rtl/rcpd_grip_map.sv
rtl/rcpd_servo.sv
rtl/rc_packet_drive_servo_controller_top.sv
sim/rc_packet_drive_servo_controller_top_tb.sv
